// ===== rtl/grr_pkg.sv =====
// ----------------------------------------------------------------------------
// grr_pkg
// Shared types and constants for the glyph row rasteriser.
// ----------------------------------------------------------------------------
`default_nettype none

package grr_pkg;

    localparam int GLYPH_WIDTH  = 8;
    localparam int GLYPH_HEIGHT = 16;
    localparam int CHAR_COUNT   = 256;
    localparam int STORE_DEPTH  = CHAR_COUNT * GLYPH_HEIGHT;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int CODE_W       = $clog2(CHAR_COUNT);
    localparam int ROW_W        = $clog2(GLYPH_HEIGHT);
    localparam int BIT_W        = $clog2(GLYPH_WIDTH);
    localparam int COORD_W      = 16;
    localparam int COLOR_W      = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 8;

    // Item commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_DRAW  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_ENABLE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION   = 2'd3;

    localparam logic [COLOR_W-1:0] FG_RESET = 8'd15;
    localparam logic [COLOR_W-1:0] BG_RESET = 8'd0;

    typedef enum logic [2:0] {
        DIR_RIGHT = 3'd0,
        DIR_UP    = 3'd1,
        DIR_LEFT  = 3'd2,
        DIR_DOWN  = 3'd3,
        DIR_DIAG  = 3'd4
    } dir_e;

    // Per-pixel coordinate step along the bit index
    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_INC  = 2'd1,
        STEP_DEC  = 2'd2
    } step_t;

    typedef struct packed {
        logic [COLOR_W-1:0] fg_color;
        logic [COLOR_W-1:0] bg_color;
        logic               fill_enable;
        dir_e               direction;
    } cfg_t;

    // Draw item waiting for the emitter, glyph byte comes from the store
    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
    } draw_t;

endpackage

`default_nettype wire

// ===== rtl/grr_ram.sv =====
// ----------------------------------------------------------------------------
// grr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module grr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/grr_emit.sv =====
// ----------------------------------------------------------------------------
// grr_emit
// Pixel emitter: walks the drawable bits of one glyph row, one write a cycle while the receiver is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module grr_emit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire grr_pkg::cfg_t                   cfg,
    input  wire logic                            draw_valid,
    input  wire grr_pkg::draw_t                  draw,
    input  wire logic [grr_pkg::GLYPH_WIDTH-1:0] glyph_bits,
    output logic                                 draw_take,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [grr_pkg::COORD_W-1:0]     px,
    output logic      [grr_pkg::COORD_W-1:0]     py,
    output logic      [grr_pkg::COLOR_W-1:0]     color,
    output logic                                 last
);

    import grr_pkg::*;

    logic [GLYPH_WIDTH-1:0] mask_reg, mask_next, mask_after, low_bit, load_mask;
    logic [GLYPH_WIDTH-1:0] bits_reg, bits_next;
    logic [COORD_W-1:0]     bx_reg, bx_next, by_reg, by_next;
    step_t                  dx_reg, dx_next, dy_reg, dy_next;
    logic [COORD_W-1:0]     load_bx, load_by;
    step_t                  load_dx, load_dy;
    logic                   load_ok;
    logic [BIT_W-1:0]       idx;
    logic [COORD_W-1:0]     offs, px_calc, py_calc;
    logic [COORD_W-1:0]     row_w;
    logic                   emit;

    logic                   out_valid_reg, out_valid_next;
    logic [COORD_W-1:0]     px_reg, py_reg;
    logic [COLOR_W-1:0]     color_reg;
    logic                   last_reg;

    function automatic logic [COORD_W-1:0] step_add(
        input logic [COORD_W-1:0] base,
        input step_t              dir,
        input logic [COORD_W-1:0] off
    );
        logic [COORD_W-1:0] res;
        case (dir)
            STEP_INC: res = base + off;
            STEP_DEC: res = base - off;
            default:  res = base;
        endcase
        return res;
    endfunction

    // Lowest pending bit
    always_comb
    begin
        idx = '0;
        for (int i = GLYPH_WIDTH - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                idx = BIT_W'(i);
            end
        end
    end

    assign low_bit    = mask_reg & (~mask_reg + 1'b1);
    assign emit       = (|mask_reg) && (!out_valid_reg || out_ready);
    assign mask_after = emit ? (mask_reg & ~low_bit) : mask_reg;
    assign draw_take  = draw_valid && (mask_after == '0);

    assign offs    = {{(COORD_W-BIT_W){1'b0}}, idx};
    assign px_calc = step_add(bx_reg, dx_reg, offs);
    assign py_calc = step_add(by_reg, dy_reg, offs);

    // Base coordinates for bit 0 and the step per bit, by orientation
    assign row_w = {{(COORD_W-ROW_W){1'b0}}, draw.row};

    always_comb
    begin
        load_ok = 1'b1;
        load_bx = draw.cx;
        load_by = draw.cy;
        load_dx = STEP_NONE;
        load_dy = STEP_NONE;
        case (cfg.direction)
            DIR_RIGHT:
            begin
                load_bx = draw.cx + COORD_W'(GLYPH_WIDTH - 1);
                load_by = draw.cy + row_w;
                load_dx = STEP_DEC;
            end
            DIR_UP:
            begin
                load_bx = draw.cx + row_w;
                load_by = draw.cy - COORD_W'(GLYPH_WIDTH - 1);
                load_dy = STEP_INC;
            end
            DIR_LEFT:
            begin
                load_bx = draw.cx - COORD_W'(GLYPH_WIDTH - 1);
                load_by = draw.cy - row_w;
                load_dx = STEP_INC;
            end
            DIR_DOWN:
            begin
                load_bx = draw.cx - row_w;
                load_by = draw.cy + COORD_W'(GLYPH_WIDTH - 1);
                load_dy = STEP_DEC;
            end
            DIR_DIAG:
            begin
                load_bx = draw.cx + (row_w + COORD_W'(GLYPH_WIDTH - 1));
                load_by = draw.cy + row_w;
                load_dx = STEP_DEC;
                load_dy = STEP_INC;
            end
            default:
            begin
                load_ok = 1'b0;
            end
        endcase
        if (!load_ok)
        begin
            load_mask = '0;
        end
        else if (cfg.fill_enable)
        begin
            load_mask = '1;
        end
        else
        begin
            load_mask = glyph_bits;
        end
    end

    always_comb
    begin
        mask_next = mask_after;
        bits_next = bits_reg;
        bx_next   = bx_reg;
        by_next   = by_reg;
        dx_next   = dx_reg;
        dy_next   = dy_reg;
        if (draw_take)
        begin
            mask_next = load_mask;
            bits_next = glyph_bits;
            bx_next   = load_bx;
            by_next   = load_by;
            dx_next   = load_dx;
            dy_next   = load_dy;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        bx_reg   <= bx_next;
        by_reg   <= by_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        if (emit)
        begin
            px_reg    <= px_calc;
            py_reg    <= py_calc;
            color_reg <= bits_reg[idx] ? cfg.fg_color : cfg.bg_color;
            last_reg  <= (mask_after == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign px        = px_reg;
    assign py        = py_reg;
    assign color     = color_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

// ===== rtl/glyph_row_rasterizer.sv =====
// ----------------------------------------------------------------------------
// glyph_row_rasterizer
// 8x16 bitmap font character generator producing pixel writes per glyph row.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one item per transfer. A write
//   item (command 0) stores font_byte at font_address in the 4096-byte glyph
//   store and yields nothing. A draw item (command 1) reads row glyph_row of
//   char_code and yields one pixel write per drawable bit, bit 0 first.
//   Output channel (out_valid/out_ready) carries one pixel write per transfer;
//   last marks the final write of a row. A row with nothing to draw, or a
//   direction code above four, yields no transfer at all.
//   A draw passes through the staged draw register and the glyph store read,
//   then the emitter mask register, then the output register. A draw yields
//   at most eight pixel writes, eight with fill on; write items are taken
//   while the emitter is busy, so long as no draw is staged. The rate, one
//   pixel write per cycle while the receiver is ready, is set by the pixel
//   emitter; the glyph store has one read port, used once per draw.
//   Configuration (cfg_we/cfg_index/cfg_data) is taken at once; change it only
//   while the block is idle. Reset restores fg 15, bg 0, fill off, direction
//   right; the glyph store is not cleared and must be written before use.
//   When the receiver stalls, the output register holds its transfer, the
//   emitter and the staged draw hold, and in_ready drops once both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_row_rasterizer (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration write port
    input  wire logic                              cfg_we,
    input  wire logic [grr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [grr_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input items
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              command,
    input  wire logic [grr_pkg::ADDR_W-1:0]        font_address,
    input  wire logic [grr_pkg::COLOR_W-1:0]       font_byte,
    input  wire logic [grr_pkg::CODE_W-1:0]        char_code,
    input  wire logic [7:0]                        char_pos,
    input  wire logic [grr_pkg::ROW_W-1:0]         glyph_row,
    input  wire logic signed [grr_pkg::COORD_W-1:0] origin_x,
    input  wire logic signed [grr_pkg::COORD_W-1:0] origin_y,
    // pixel writes
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [grr_pkg::COORD_W-1:0]     pixel_x,
    output logic signed [grr_pkg::COORD_W-1:0]     pixel_y,
    output logic        [grr_pkg::COLOR_W-1:0]     pixel_color,
    output logic                                   last
);

    import grr_pkg::*;

    cfg_t               cfg_reg, cfg_next;
    logic               s1_valid_reg, s1_valid_next;
    draw_t              s1_reg, s1_next;
    logic               accept, draw_accept, write_accept;
    logic               draw_take;
    logic [COORD_W-1:0] adv;
    logic [GLYPH_WIDTH-1:0] glyph_bits;
    logic [COORD_W-1:0] px, py;

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_FG_COLOR:    cfg_next.fg_color    = cfg_data;
                REG_BG_COLOR:    cfg_next.bg_color    = cfg_data;
                REG_FILL_ENABLE: cfg_next.fill_enable = cfg_data[0];
                REG_DIRECTION:   cfg_next.direction   = dir_e'(cfg_data[2:0]);
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // Accept a new item whenever the staged draw is empty or moving on
    assign in_ready     = !s1_valid_reg || draw_take;
    assign accept       = in_valid && in_ready;
    assign draw_accept  = accept && (command == CMD_DRAW);
    assign write_accept = accept && (command == CMD_WRITE);

    // String advance: eight pixels per character position
    assign adv = {{(COORD_W-8-BIT_W){1'b0}}, char_pos, {BIT_W{1'b0}}};

    // Move the string origin to the character origin along the text direction
    always_comb
    begin
        s1_next     = s1_reg;
        s1_next.row = glyph_row;
        s1_next.cx  = origin_x;
        s1_next.cy  = origin_y;
        case (cfg_reg.direction)
            DIR_RIGHT: s1_next.cx = origin_x + adv;
            DIR_UP:    s1_next.cy = origin_y - adv;
            DIR_LEFT:  s1_next.cx = origin_x - adv;
            DIR_DOWN:  s1_next.cy = origin_y + adv;
            DIR_DIAG:
            begin
                s1_next.cx = origin_x + adv;
                s1_next.cy = origin_y - adv;
            end
            default:   s1_next.cx = origin_x;
        endcase
        if (!draw_accept)
        begin
            s1_next = s1_reg;
        end
        if (draw_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (draw_take)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fg_color    <= FG_RESET;
            cfg_reg.bg_color    <= BG_RESET;
            cfg_reg.fill_enable <= 1'b0;
            cfg_reg.direction   <= DIR_RIGHT;
            s1_valid_reg        <= 1'b0;
        end
        else
        begin
            cfg_reg      <= cfg_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

    // Glyph store: the read data holds until the next draw is accepted, so a
    // staged draw keeps its row until the emitter takes it.
    grr_ram #(
        .WIDTH (GLYPH_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (write_accept),
        .waddr (font_address),
        .wdata (font_byte),
        .re    (draw_accept),
        .raddr ({char_code, glyph_row}),
        .rdata (glyph_bits)
    );

    grr_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .draw_valid (s1_valid_reg),
        .draw       (s1_reg),
        .glyph_bits (glyph_bits),
        .draw_take  (draw_take),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .px         (px),
        .py         (py),
        .color      (pixel_color),
        .last       (last)
    );

    assign pixel_x = signed'(px);
    assign pixel_y = signed'(py);

endmodule

`default_nettype wire
